// ----- sv/sec_pkg.sv -----
// ----------------------------------------------------------------------------
// sec_pkg
// shared types, constants and the exp table for the covariance core
// ----------------------------------------------------------------------------
`default_nettype none

package sec_pkg;

  localparam int unsigned EXP_TABLE_DEPTH = 256;
  localparam int unsigned IDX_W = $clog2(EXP_TABLE_DEPTH);
  localparam longint unsigned LN2_Q30 = 64'd744261118;
  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
  localparam logic [63:0] X_LIMIT_Q24 = 64'd16 << 24;

  localparam logic [1:0] REG_DIM   = 2'd0;
  localparam logic [1:0] REG_COEF  = 2'd1;
  localparam logic [1:0] REG_SIGVAR = 2'd2;
  localparam logic [1:0] REG_NOISE = 2'd3;

  // reciprocals of 1..20 in q.36, exact floor division for numerators below 2^31
  localparam longint unsigned RECIP_ONE = 64'd1 << 36;
  localparam longint unsigned RECIP_Q36 [20] = '{
    RECIP_ONE / 64'd1 + 64'd1,  RECIP_ONE / 64'd2 + 64'd1,  RECIP_ONE / 64'd3 + 64'd1,
    RECIP_ONE / 64'd4 + 64'd1,  RECIP_ONE / 64'd5 + 64'd1,  RECIP_ONE / 64'd6 + 64'd1,
    RECIP_ONE / 64'd7 + 64'd1,  RECIP_ONE / 64'd8 + 64'd1,  RECIP_ONE / 64'd9 + 64'd1,
    RECIP_ONE / 64'd10 + 64'd1, RECIP_ONE / 64'd11 + 64'd1, RECIP_ONE / 64'd12 + 64'd1,
    RECIP_ONE / 64'd13 + 64'd1, RECIP_ONE / 64'd14 + 64'd1, RECIP_ONE / 64'd15 + 64'd1,
    RECIP_ONE / 64'd16 + 64'd1, RECIP_ONE / 64'd17 + 64'd1, RECIP_ONE / 64'd18 + 64'd1,
    RECIP_ONE / 64'd19 + 64'd1, RECIP_ONE / 64'd20 + 64'd1
  };

  typedef logic [31:0] exp_rom_t [EXP_TABLE_DEPTH+1];

  typedef struct packed {
    logic [63:0] dsum;
    logic        sat;
    logic        noise;
  } job_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_HI,
    ST_MUL_LO,
    ST_LOG,
    ST_TAB,
    ST_INTERP,
    ST_SHIFT,
    ST_SCALE,
    ST_FIN
  } bk_state_e;

  function automatic logic [31:0] exp_neg_q30(longint unsigned t);
    longint unsigned term;
    longint unsigned even;
    longint unsigned odd;
    logic [127:0]    prod;
    term = 64'd1 << 30;
    even = term;
    odd  = 0;
    for (int n = 1; n <= 20; n++) begin
      prod = 128'((term * t) >> 30) * 128'(RECIP_Q36[n-1]);
      term = 64'(prod >> 36);
      if (n % 2 == 1) odd += term;
      else even += term;
    end
    return (even > odd) ? 32'(even - odd) : 32'd0;
  endfunction

  function automatic exp_rom_t build_exp_rom();
    exp_rom_t rom;
    longint unsigned t;
    for (int i = 0; i <= EXP_TABLE_DEPTH; i++) begin
      t = (longint'(i) * LN2_Q30 + EXP_TABLE_DEPTH / 2) / EXP_TABLE_DEPTH;
      rom[i] = exp_neg_q30(t);
    end
    return rom;
  endfunction

  localparam exp_rom_t EXP_ROM = build_exp_rom();

endpackage

`default_nettype wire

// ----- sv/sec_fifo.sv -----
// ----------------------------------------------------------------------------
// sec_fifo
// two-entry queue of finished distances between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module sec_fifo import sec_pkg::*; (
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  push_i,
  input  job_t push_data_i,
  output logic full_o,
  input  wire  pop_i,
  output logic empty_o,
  output job_t pop_data_o
);

  job_t mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  assign full_o     = (cnt_q == 2'd2);
  assign empty_o    = (cnt_q == 2'd0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i) rd_ptr_q <= ~rd_ptr_q;
      if (push_i && !pop_i) cnt_q <= cnt_q + 2'd1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 2'd1;
    end
  end

endmodule

`default_nettype wire

// ----- sv/sec_front.sv -----
// ----------------------------------------------------------------------------
// sec_front
// accepts coordinate pairs and accumulates the saturating squared distance
// ----------------------------------------------------------------------------
`default_nettype none

module sec_front import sec_pkg::*; #(
  parameter int unsigned MAX_DIMS = 64
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_ready_o,
  input  wire signed [23:0] coord_a_i,
  input  wire signed [23:0] coord_b_i,
  input  wire               add_noise_i,
  input  wire        [6:0]  dimension_count_i,
  input  wire               q_full_i,
  output logic              q_push_o,
  output job_t              q_data_o
);

  localparam int unsigned CW = $clog2(MAX_DIMS + 1);

  logic [63:0]   sum_q;
  logic [CW-1:0] count_q;
  logic          ovf_q;

  logic signed [24:0] diff;
  logic [23:0]        absd;
  logic [47:0]        sq;
  logic [64:0]        sum_wide;
  logic [63:0]        sum_new;
  logic               ovf_new;
  logic [CW-1:0]      n_eff;
  logic [CW:0]        count_inc;
  logic               accept, last;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    diff      = 25'(coord_a_i) - 25'(coord_b_i);
    absd      = diff[24] ? 24'(-diff) : diff[23:0];
    sq        = 48'(absd) * 48'(absd);
    sum_wide  = {1'b0, sum_q} + 65'(sq);
    sum_new   = sum_wide[64] ? '1 : sum_wide[63:0];
    ovf_new   = ovf_q || sum_wide[64];
    if (dimension_count_i == 7'd0) n_eff = CW'(1);
    else if (32'(dimension_count_i) > 32'(MAX_DIMS)) n_eff = CW'(MAX_DIMS);
    else n_eff = CW'(dimension_count_i);
    count_inc = {1'b0, count_q} + (CW+1)'(1);
    last      = count_inc >= {1'b0, n_eff};
  end

  assign q_push_o       = accept && last;
  assign q_data_o.dsum  = sum_new;
  assign q_data_o.sat   = ovf_new;
  assign q_data_o.noise = add_noise_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else if (accept) begin
      if (last) begin
        sum_q   <= '0;
        count_q <= '0;
        ovf_q   <= 1'b0;
      end else begin
        sum_q   <= sum_new;
        count_q <= count_inc[CW-1:0];
        ovf_q   <= ovf_new;
      end
    end
  end

endmodule

`default_nettype wire

// ----- sv/sec_back.sv -----
// ----------------------------------------------------------------------------
// sec_back
// multi-cycle exp evaluation, scaling, noise add and result register
// ----------------------------------------------------------------------------
`default_nettype none

module sec_back import sec_pkg::*; (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         q_empty_i,
  input  job_t        q_data_i,
  output logic        q_pop_o,
  input  wire  [31:0] exp_coefficient_i,
  input  wire  [31:0] signal_variance_i,
  input  wire  [31:0] diag_noise_i,
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output logic [31:0] covariance_o,
  output logic        saturated_o
);

  bk_state_e state_q, state_d;

  logic [63:0]      dist_q;
  logic             sat_q, noise_q, zero_q;
  logic [63:0]      hp_q;
  logic [27:0]      x_q;
  logic [4:0]       k_q;
  logic [IDX_W-1:0] idx_q;
  logic [15:0]      w_q;
  logic [31:0]      a_q, b_q;
  logic [31:0]      v_q;
  logic [16:0]      e16_q;
  logic [48:0]      prod_q;
  logic             out_valid_q;
  logic [31:0]      cov_q;
  logic             osat_q;

  logic [63:0] lp;
  logic [32:0] x_sum;
  logic [58:0] y;
  logic [47:0] dw;
  logic [31:0] vs;
  logic [32:0] rnd;
  logic [33:0] cov_sum;
  logic        fin_go;

  assign out_valid_o  = out_valid_q;
  assign covariance_o = cov_q;
  assign saturated_o  = osat_q;

  always_comb begin
    lp      = 64'(exp_coefficient_i) * 64'(dist_q[31:0]);
    x_sum   = 33'(hp_q[27:0]) + 33'(lp[63:32]);
    y       = 59'(x_q) * 59'(LOG2E_Q30);
    dw      = 48'(a_q - b_q) * 48'(w_q);
    vs      = v_q >> k_q;
    rnd     = 33'(prod_q >> 16) + 33'(prod_q[15]);
    cov_sum = 34'(rnd) + (noise_q ? 34'(diag_noise_i) : 34'd0);
    fin_go  = !out_valid_q || out_ready_i;
  end

  always_comb begin
    state_d = state_q;
    q_pop_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          state_d = ST_MUL_HI;
        end
      end
      ST_MUL_HI: state_d = ST_MUL_LO;
      ST_MUL_LO: state_d = ST_LOG;
      ST_LOG:    state_d = ST_TAB;
      ST_TAB:    state_d = ST_INTERP;
      ST_INTERP: state_d = ST_SHIFT;
      ST_SHIFT:  state_d = ST_SCALE;
      ST_SCALE:  state_d = ST_FIN;
      ST_FIN: begin
        if (fin_go) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // datapath, one step per state
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        dist_q  <= q_data_i.dsum;
        sat_q   <= q_data_i.sat;
        noise_q <= q_data_i.noise;
      end
      ST_MUL_HI: hp_q <= 64'(exp_coefficient_i) * 64'(dist_q[63:32]);
      ST_MUL_LO: begin
        zero_q <= (hp_q >= X_LIMIT_Q24) || (64'(x_sum) >= X_LIMIT_Q24);
        x_q    <= x_sum[27:0];
      end
      ST_LOG: begin
        k_q   <= y[58:54];
        idx_q <= y[53:54-IDX_W];
        w_q   <= y[53-IDX_W:38-IDX_W];
      end
      ST_TAB: begin
        a_q <= EXP_ROM[idx_q];
        b_q <= EXP_ROM[(IDX_W+1)'(idx_q) + (IDX_W+1)'(1)];
      end
      ST_INTERP: v_q <= a_q - dw[47:16];
      ST_SHIFT:  e16_q <= zero_q ? 17'd0 : 17'((33'(vs) + 33'd8192) >> 14);
      ST_SCALE:  prod_q <= 49'(signal_variance_i) * 49'(e16_q);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_FIN && fin_go) begin
      cov_q  <= (cov_sum[33:32] != 2'd0) ? '1 : cov_sum[31:0];
      osat_q <= sat_q || (cov_sum[33:32] != 2'd0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_FIN && fin_go) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ----- sv/squared_exponential_covariance_core.sv -----
// ----------------------------------------------------------------------------
// squared_exponential_covariance_core
// squared exponential kernel engine with apb register port
// ----------------------------------------------------------------------------
// Each transfer on the input channel carries one coordinate of two points and
// the front accumulates the squared distance. After dimension_count transfers
// the distance goes into a two-entry queue and the back computes
// signal_variance * exp(-coef * distance) (+ noise) in steps (multiply, log2,
// table, interpolate, shift, scale, final add), taking a new distance only once
// the last result is registered; the front only stalls when the queue is full.
// Registers: 0x0 dimension_count, 0x4 exp_coefficient, 0x8 signal_variance,
// 0xc diagonal noise.
`default_nettype none

module squared_exponential_covariance_core import sec_pkg::*; #(
  parameter int unsigned MAX_DIMS = 64
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [3:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  wire  [23:0] coord_a_i,
  input  wire  [23:0] coord_b_i,
  input  wire         add_noise_i,
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output logic [31:0] covariance_o,
  output logic        saturated_o
);

  logic [6:0]  dim_q;
  logic [31:0] coef_q, sigvar_q, noise_q;

  logic q_push, q_pop, q_full, q_empty;
  job_t q_wdata, q_rdata;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_q    <= 7'd1;
      coef_q   <= 32'd16777216;
      sigvar_q <= 32'd65536;
      noise_q  <= 32'd0;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_DIM:    dim_q    <= pwdata[6:0];
        REG_COEF:   coef_q   <= pwdata;
        REG_SIGVAR: sigvar_q <= pwdata;
        REG_NOISE:  noise_q  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_DIM:    prdata = 32'(dim_q);
      REG_COEF:   prdata = coef_q;
      REG_SIGVAR: prdata = sigvar_q;
      REG_NOISE:  prdata = noise_q;
      default:    prdata = '0;
    endcase
  end

  sec_front #(.MAX_DIMS(MAX_DIMS)) u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .coord_a_i         (signed'(coord_a_i)),
    .coord_b_i         (signed'(coord_b_i)),
    .add_noise_i,
    .dimension_count_i (dim_q),
    .q_full_i          (q_full),
    .q_push_o          (q_push),
    .q_data_o          (q_wdata)
  );

  sec_fifo u_fifo (
    .clk_i,
    .rst_ni,
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .pop_data_o  (q_rdata)
  );

  sec_back u_back (
    .clk_i,
    .rst_ni,
    .q_empty_i         (q_empty),
    .q_data_i          (q_rdata),
    .q_pop_o           (q_pop),
    .exp_coefficient_i (coef_q),
    .signal_variance_i (sigvar_q),
    .diag_noise_i      (noise_q),
    .out_valid_o,
    .out_ready_i,
    .covariance_o,
    .saturated_o
  );

endmodule

`default_nettype wire
